/* sv/msbe_pkg.sv */
// ----------------------------------------------------------------------------
// Mid/side band energy package
// Shared sizes, register codes and beat types of the band energy core.
// ----------------------------------------------------------------------------
package msbe_pkg;

	localparam int SAMPLE_BITS    = 20;
	localparam int MAX_BAND_LINES = 128;

	// Mid/side values are one bit wider than a sample.
	localparam int VAL_W    = SAMPLE_BITS + 1;
	localparam int ENERGY_W = 2 * SAMPLE_BITS + 1;
	// Worst case sum is MAX_BAND_LINES lines of 2^(2*SAMPLE_BITS) each.
	localparam int SUM_W    = ENERGY_W + $clog2(MAX_BAND_LINES);
	localparam int COUNT_W  = $clog2(MAX_BAND_LINES + 1);
	localparam int STEP_W   = $clog2(SUM_W + 1);
	localparam int LINES_W  = 8;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int MODE_W  = 2;

	localparam logic [PADDR_W-3:0] REG_MS_MODE = '0;

	localparam logic [MODE_W-1:0] MS_NEVER  = MODE_W'(0);
	localparam logic [MODE_W-1:0] MS_FLAG   = MODE_W'(1);
	localparam logic [MODE_W-1:0] MS_ALWAYS = MODE_W'(2);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_line;
		logic signed [SAMPLE_BITS-1:0] right_line;
		logic                          band_ms_flag;
		logic                          band_last;
	} line_beat_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy_first;
		logic [ENERGY_W-1:0] energy_second;
		logic [LINES_W-1:0]  band_lines;
		logic                too_long;
	} band_beat_t;

	typedef struct packed {
		logic vld;
		logic add;
		logic last;
	} lane_ctl_t;

	typedef struct packed {
		logic                done;
		logic [ENERGY_W-1:0] quot;
	} lane_stat_t;

endpackage

/* sv/msbe_lane.sv */
// ----------------------------------------------------------------------------
// Band energy lane
// Squares one value per beat, accumulates the band sum and divides it by the
// line count at band end with a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module msbe_lane
	import msbe_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctl_t               ctl,
	input  logic signed [VAL_W-1:0] value,
	input  logic [COUNT_W-1:0]      divisor,
	input  logic                    take,
	output lane_stat_t              stat
);

	typedef enum logic [2:0] {
		LANE_IDLE = 3'b001,
		LANE_DIV  = 3'b010,
		LANE_DONE = 3'b100
	} lane_state_t;

	lane_state_t         state_q;
	lane_ctl_t           ctl_s1;
	lane_ctl_t           ctl_s2;
	logic [VAL_W-1:0]    value_s1;
	logic [ENERGY_W-1:0] sq_s2;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    div_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [STEP_W-1:0]   step_q;

	logic [VAL_W-1:0]    mag;
	logic [2*VAL_W-1:0]  square;
	logic [SUM_W-1:0]    sum_inc;
	logic [COUNT_W:0]    trial;
	logic [COUNT_W:0]    diff;
	logic                fits;
	logic                start;

	always_comb begin
		mag     = value_s1[VAL_W-1] ? (~value_s1 + 1'b1) : value_s1;
		square  = mag * mag;
		sum_inc = sum_q + (ctl_s2.add ? SUM_W'(sq_s2) : '0);
		trial   = {rem_q, div_q[SUM_W-1]};
		diff    = trial - {1'b0, divisor};
		fits    = trial >= {1'b0, divisor};
		start   = ctl_s2.vld && ctl_s2.last && (state_q == LANE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			sum_q   <= '0;
			step_q  <= '0;
			state_q <= LANE_IDLE;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			if (ctl_s2.vld) begin
				sum_q <= ctl_s2.last ? '0 : sum_inc;
			end
			case (state_q)
				LANE_IDLE: begin
					if (start) begin
						step_q  <= '0;
						state_q <= LANE_DIV;
					end
				end
				LANE_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= LANE_DONE;
					end
				end
				LANE_DONE: begin
					if (take) begin
						state_q <= LANE_IDLE;
					end
				end
				default: begin
					state_q <= LANE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			value_s1 <= value;
		end
		sq_s2 <= square[ENERGY_W-1:0];
		if (start) begin
			div_q <= sum_inc;
			rem_q <= '0;
		end else if (state_q == LANE_DIV) begin
			// The dividend shifts out at the top while quotient bits enter below.
			div_q <= {div_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
		end
	end

	assign stat.done = (state_q == LANE_DONE);
	assign stat.quot = div_q[ENERGY_W-1:0];

endmodule

/* sv/msbe_merge.sv */
// ----------------------------------------------------------------------------
// Band result merge
// Joins both lane quotients with the count and overflow mark into the
// output register and hands each band result out as one beat.
// ----------------------------------------------------------------------------
module msbe_merge
	import msbe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lane_stat_t         first,
	input  lane_stat_t         second,
	input  logic [COUNT_W-1:0] count,
	input  logic               too_long,
	input  logic               band_stall,
	output logic               band_valid,
	output band_beat_t         band,
	output logic               take
);

	logic       valid_q;
	band_beat_t band_q;

	assign take = first.done && second.done && (!valid_q || !band_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
			end else if (!band_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			band_q.energy_first  <= first.quot;
			band_q.energy_second <= second.quot;
			band_q.band_lines    <= LINES_W'(count);
			band_q.too_long      <= too_long;
		end
	end

	assign band_valid = valid_q;
	assign band       = band_q;

endmodule

/* sv/mid_side_band_energy_core.sv */
// ----------------------------------------------------------------------------
// Mid/side band energy core
// Forms mid/side or scaled left/right values per line pair, accumulates their
// squares in two lanes and emits both band mean energies at each band end.
// ----------------------------------------------------------------------------
// Lines that do not end a band are taken one per cycle while line_stall is low.
// A band end result passes the lane stages ctl_s1 and ctl_s2, the restoring
// dividers in the lanes, one quotient bit a cycle, and the merge output
// register; line input stalls from the last line until it is registered.
// Reset clears the sums, count, overflow mark and output valid, and sets
// ms_mode to follow the per-band flag.
module mid_side_band_energy_core
	import msbe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               line_valid,
	output logic               line_stall,
	input  line_beat_t         line,
	output logic               band_valid,
	input  logic               band_stall,
	output band_beat_t         band
);

	logic [MODE_W-1:0]  mode_q;
	logic [COUNT_W-1:0] count_q;
	logic               ovf_q;
	logic               busy_q;
	logic [COUNT_W-1:0] band_cnt_q;
	logic               band_ovf_q;

	logic                    accept;
	logic                    use_ms;
	logic                    room;
	logic signed [VAL_W-1:0] l_ext;
	logic signed [VAL_W-1:0] r_ext;
	logic signed [VAL_W-1:0] val_first;
	logic signed [VAL_W-1:0] val_second;
	lane_ctl_t               ctl;
	lane_stat_t              st_first;
	lane_stat_t              st_second;
	logic                    take;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1:2] == REG_MS_MODE) begin
			prdata = PDATA_W'(mode_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MS_FLAG;
		end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_MS_MODE)) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign line_stall = busy_q;
	assign accept     = line_valid && !line_stall;
	assign room       = count_q < COUNT_W'(MAX_BAND_LINES);

	always_comb begin
		case (mode_q)
			MS_NEVER: use_ms = 1'b0;
			MS_FLAG:  use_ms = line.band_ms_flag;
			default:  use_ms = 1'b1;
		endcase
		l_ext = {line.left_line[SAMPLE_BITS-1], line.left_line};
		r_ext = {line.right_line[SAMPLE_BITS-1], line.right_line};
		if (use_ms) begin
			val_first  = l_ext + r_ext;
			val_second = l_ext - r_ext;
		end else begin
			val_first  = {line.left_line, 1'b0};
			val_second = {line.right_line, 1'b0};
		end
		ctl.vld  = accept;
		ctl.add  = room;
		ctl.last = line.band_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (line.band_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					busy_q  <= 1'b1;
				end else if (room) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (take) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The divisor and overflow mark hold while the lanes divide.
	always_ff @(posedge clk) begin
		if (accept && line.band_last) begin
			band_cnt_q <= room ? count_q + 1'b1 : count_q;
			band_ovf_q <= ovf_q || !room;
		end
	end

	msbe_lane u_lane_first (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.value   (val_first),
		.divisor (band_cnt_q),
		.take    (take),
		.stat    (st_first)
	);

	msbe_lane u_lane_second (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.value   (val_second),
		.divisor (band_cnt_q),
		.take    (take),
		.stat    (st_second)
	);

	msbe_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.first      (st_first),
		.second     (st_second),
		.count      (band_cnt_q),
		.too_long   (band_ovf_q),
		.band_stall (band_stall),
		.band_valid (band_valid),
		.band       (band),
		.take       (take)
	);

	// Both lanes run in lockstep on the same beats.
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		st_first.done == st_second.done)
		else $error("lanes finished division at different cycles");

	// A finished division only exists while line input is held off.
	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_first.done |-> busy_q)
		else $error("lane result pending while lines are accepted");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && line.band_last) |=> line_stall)
		else $error("line input not stalled after band end");

	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> band_valid && !busy_q)
		else $error("band result not presented after merge");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Mid/side band energy core testbench
// Streams line pairs through the core under every ms_mode code, predicts each
// band's mean energies, count and overflow mark, and checks every band beat.
// ----------------------------------------------------------------------------
module tb;
	import msbe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;
	// The settle wait covers the core's path from a band's last line to its result.
	localparam int SETTLE_CYCLES = SUM_W + 3 + 10;
	localparam int PHASE_LINES = 195;

	localparam logic [PADDR_W-1:0] MODE_ADDR = {REG_MS_MODE, 2'b00};
	localparam logic [MODE_W-1:0] MS_SPARE = MODE_W'(3);

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	logic line_valid = 1'b0;
	logic line_stall;
	line_beat_t line = '0;
	logic band_valid;
	logic band_stall = 1'b0;
	band_beat_t band;

	mid_side_band_energy_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.line_valid(line_valid),
		.line_stall(line_stall),
		.line(line),
		.band_valid(band_valid),
		.band_stall(band_stall),
		.band(band)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	line_beat_t pending_lines[$];
	band_beat_t expected_bands[$];

	// Predictor state: mode copy, band sums, line count and drop mark.
	logic [MODE_W-1:0] cur_mode = MS_FLAG;
	logic [63:0] acc_first = '0;
	logic [63:0] acc_second = '0;
	int acc_lines = 0;
	logic acc_dropped = 1'b0;

	int errors = 0;
	int cycles = 0;
	int lines_taken = 0;
	int bands_checked = 0;
	int overlong_bands = 0;

	logic calm = 1'b0;
	int gap_left = 0;
	int burst_left = 0;
	logic stall_state = 1'b0;
	int stall_left = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	function automatic logic [63:0] square_of(input logic signed [SAMPLE_BITS+1:0] v);
		logic [63:0] m;
		m = 64'(v < 0 ? -v : v);
		return m * m;
	endfunction

	task automatic accumulate_line(input line_beat_t b);
		logic signed [SAMPLE_BITS+1:0] lv, rv, va, vb;
		logic mid_side;
		band_beat_t r;
		lv = $signed(b.left_line);
		rv = $signed(b.right_line);
		case (cur_mode)
			MS_NEVER: mid_side = 1'b0;
			MS_FLAG: mid_side = b.band_ms_flag;
			default: mid_side = 1'b1;
		endcase
		if (mid_side) begin
			va = lv + rv;
			vb = lv - rv;
		end else begin
			va = lv + lv;
			vb = rv + rv;
		end
		if (acc_lines < MAX_BAND_LINES) begin
			acc_first += square_of(va);
			acc_second += square_of(vb);
			acc_lines++;
		end else begin
			acc_dropped = 1'b1;
		end
		if (b.band_last) begin
			r.energy_first = ENERGY_W'(acc_first / 64'(acc_lines));
			r.energy_second = ENERGY_W'(acc_second / 64'(acc_lines));
			r.band_lines = LINES_W'(acc_lines);
			r.too_long = acc_dropped;
			if (acc_dropped)
				overlong_bands++;
			expected_bands.push_back(r);
			acc_first = '0;
			acc_second = '0;
			acc_lines = 0;
			acc_dropped = 1'b0;
		end
	endtask

	// Line driver: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			line_valid <= 1'b0;
		end else begin
			if (line_valid && !line_stall) begin
				accumulate_line(line);
				lines_taken++;
			end
			if (!line_valid || !line_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					line_valid <= 1'b0;
				end else if (pending_lines.size() > 0) begin
					line <= pending_lines.pop_front();
					line_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						case ($urandom_range(0, 7))
							0, 1: gap_left = 0;
							7: gap_left = $urandom_range(40, 60);
							default: gap_left = $urandom_range(1, 6);
						endcase
						if (calm)
							gap_left = 0;
					end
				end else begin
					line_valid <= 1'b0;
				end
			end
		end
	end

	// Band monitor: checks each accepted band beat and stalls on its own pattern.
	always @(posedge clk) begin
		if (!arst_n) begin
			band_stall <= 1'b0;
		end else begin
			if (band_valid && !band_stall) begin
				bands_checked++;
				if (expected_bands.size() == 0) begin
					report("band beat with nothing expected", 64'(band.band_lines), '0);
				end else begin
					band_beat_t want;
					want = expected_bands.pop_front();
					if (band.energy_first !== want.energy_first)
						report("energy_first", 64'(band.energy_first), 64'(want.energy_first));
					if (band.energy_second !== want.energy_second)
						report("energy_second", 64'(band.energy_second),
							64'(want.energy_second));
					if (band.band_lines !== want.band_lines)
						report("band_lines", 64'(band.band_lines), 64'(want.band_lines));
					if (band.too_long !== want.too_long)
						report("too_long", 64'(band.too_long), 64'(want.too_long));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
			end else begin
				stall_state = calm ? 1'b0 : !stall_state;
				stall_left = stall_state ? $urandom_range(1, 12) : $urandom_range(0, 70);
			end
			band_stall <= stall_state;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timed out after %0d cycles with %0d band beats outstanding",
				cycles, expected_bands.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(input logic [MODE_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MODE_ADDR;
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cur_mode = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_check(input logic [MODE_W-1:0] want);
		logic [PDATA_W-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= MODE_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== PDATA_W'(want))
			report("ms_mode read back", 64'(got), 64'(want));
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_lines.size() != 0 || line_valid || expected_bands.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SMP_MIN;
			1: return SMP_MAX;
			2, 3: return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic void push_line(input logic signed [SAMPLE_BITS-1:0] l,
		input logic signed [SAMPLE_BITS-1:0] r, input logic flag, input logic last);
		line_beat_t b;
		b.left_line = l;
		b.right_line = r;
		b.band_ms_flag = flag;
		b.band_last = last;
		pending_lines.push_back(b);
	endfunction

	// Queues one band; a mixed band picks its mid/side flag at random for each line.
	function automatic int push_band(input int n_lines, input logic mixed);
		logic flag;
		flag = 1'($urandom_range(0, 1));
		for (int i = 0; i < n_lines; i++)
			push_line(pick_sample(), pick_sample(),
				mixed ? 1'($urandom_range(0, 1)) : flag, i == n_lines - 1);
		return n_lines;
	endfunction

	initial begin
		logic [MODE_W-1:0] modes[4];
		int queued;
		int n;
		modes = '{MS_NEVER, MS_ALWAYS, MS_SPARE, MS_FLAG};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		reg_check(MS_FLAG);

		// Extremes first, in the reset mode that follows the per-band flag.
		@(negedge clk);
		push_line(SMP_MAX, SMP_MAX, 1'b1, 1'b1);
		push_line(SMP_MIN, SMP_MIN, 1'b1, 1'b1);
		push_line(SMP_MIN, SMP_MIN, 1'b0, 1'b1);
		push_line(SMP_MIN, SMP_MAX, 1'b1, 1'b1);
		push_line(SMP_MAX, SMP_MIN, 1'b0, 1'b1);
		push_line(SMP_MAX, SMP_MIN, 1'b1, 1'b1);
		push_line('0, '0, 1'b0, 1'b1);
		push_line(SMP_MIN, SMP_MAX, 1'b1, 1'b0);
		push_line(SMP_MAX, SMP_MAX, 1'b0, 1'b0);
		push_line(SMP_MIN, SMP_MIN, 1'b1, 1'b1);
		push_line(20'sd5, 20'sd3, 1'b1, 1'b0);
		push_line(20'sd0, 20'sd1, 1'b1, 1'b0);
		push_line(20'sd7, -20'sd2, 1'b0, 1'b1);
		push_line(-20'sd1, 20'sd1, 1'b1, 1'b0);
		push_line(20'sd1, -20'sd1, 1'b1, 1'b1);
		wait_idle();

		foreach (modes[p]) begin
			reg_write(modes[p]);
			reg_check(modes[p]);
			@(negedge clk);
			calm = (p == 1);
			// One band around the length limit per phase: 127, 128, 129 and 130 lines.
			queued = push_band(MAX_BAND_LINES - 1 + p, 1'b0);
			while (queued < PHASE_LINES) begin
				n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 8);
				queued += push_band(n, $urandom_range(0, 4) == 0);
			end
			wait_idle();
		end

		$display("checked %0d band beats from %0d line beats, %0d of them overlong,",
			bands_checked, lines_taken, overlong_bands);
		$display("under all four ms_mode codes with random source gaps and sink stalls");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/msbe_pkg.sv
sv/msbe_lane.sv
sv/msbe_merge.sv
sv/mid_side_band_energy_core.sv
verif/tb.sv
